// File: rtl/core/fat_chain_block_allocator_defines.svh
// Assertion macros used by the checker file.
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_DEFINES_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define FCBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fcba_pkg.sv
// ---------------------------------------------------------------------------
// fcba_pkg
// Shared types and constants for the chained block allocator.
// ---------------------------------------------------------------------------
package fcba_pkg;
    localparam int BLOCK_COUNT = 256;
    localparam int BLOCK_BYTES = 4096;
    localparam int BLK_W       = $clog2(BLOCK_COUNT);
    localparam int CNT_W       = 12;
    localparam int LINK_W      = BLK_W + 1;

    localparam logic [2:0] KIND_ALLOC = 3'd0;
    localparam logic [2:0] KIND_OPEN  = 3'd1;
    localparam logic [2:0] KIND_APPND = 3'd2;
    localparam logic [2:0] KIND_CLOSE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NOWRITE = 2'd2;

    localparam logic [0:0] REG_CAP = 1'b0;
    localparam logic [0:0] REG_USE = 1'b1;

    typedef logic [BLK_W-1:0] blk_t;
endpackage

// File: rtl/core/fcba_ram.sv
// ---------------------------------------------------------------------------
// fcba_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module fcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/fat_chain_block_allocator.sv
// ---------------------------------------------------------------------------
// fat_chain_block_allocator
// FAT-style allocator: free map, link table and write cursor for chained blocks.
// ---------------------------------------------------------------------------
// Input channel (valid/stall): kind, block_index, data_byte. One transaction
// in, one result transaction out, in order. Output channel carries status,
// block_number, chain_end, byte_offset and byte_out.
// Items are processed one at a time. The link table is a RAM with registered
// read data; the free map is a flag vector searched by a sequencer that
// scans one block a cycle from the low end.
// Steps: close, plain append and unused kinds go straight to the result; read
// link reads the link RAM (S_RDLNK); alloc scans the free map (S_SRCH); an
// append that links a new block scans, links it and ends it (S_LINK2); open
// reads the head (S_OPNRD), walks and frees the old chain, then ends the head.
// The next item is taken no earlier than the edge at which the result is
// taken.
// Reset marks every block free, closes the write and loads register defaults;
// link entries stay undefined until written, no clearing pass is needed.
// When the receiver stalls the result holds and input stall stays high until
// the result is taken.
// APB: block_capacity at 0x0, blocks_in_use at 0x4.
// ---------------------------------------------------------------------------
module fat_chain_block_allocator
    import fcba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  block_index,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  block_number,
    output logic        chain_end,
    output logic [11:0] byte_offset,
    output logic [7:0]  byte_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_OPNRD = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_RDLNK = 4'd5;
    localparam logic [3:0] S_LINK2 = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]        state_reg, state_next;
    logic [2:0]        kind_reg;
    blk_t              idx_reg;
    logic [7:0]        byte_reg;
    logic [BLOCK_COUNT-1:0] free_reg;
    blk_t              cur_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              open_reg;
    logic [11:0]       cap_reg;
    logic [8:0]        use_reg;
    blk_t              scan_reg;
    blk_t              found_reg;
    logic [BLK_W:0]    steps_reg;

    logic [1:0]  r_status_reg;
    blk_t        r_blk_reg;
    logic        r_end_reg;
    logic [11:0] r_off_reg;
    logic [7:0]  r_byte_reg;
    logic        out_valid_reg;

    logic          we;
    blk_t          waddr, raddr;
    logic [LINK_W-1:0] wdata, rdata;

    fcba_ram #(.WIDTH(LINK_W), .DEPTH(BLOCK_COUNT)) u_link (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic        in_acc, out_acc, res_load;
    logic [12:0] cap_eff;
    logic [8:0]  lim;
    logic        scan_end;
    blk_t        nxt_blk;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && !out_acc);
    assign res_load = (state_reg == S_DONE) && (!out_valid_reg || out_acc);
    assign cap_eff  = ({1'b0, cap_reg} > 13'(BLOCK_BYTES)) ? 13'(BLOCK_BYTES)
                                                          : {1'b0, cap_reg};
    assign lim      = (use_reg > 9'(BLOCK_COUNT)) ? 9'(BLOCK_COUNT) : use_reg;
    assign scan_end = ({1'b0, scan_reg} + 9'd1) >= lim;
    assign nxt_blk  = rdata[BLK_W-1:0];

    // Link RAM port control
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = {1'b1, {BLK_W{1'b0}}};
        raddr = idx_reg;
        unique case (state_reg)
            S_SRCH:
            begin
                if (free_reg[scan_reg] && {1'b0, scan_reg} < lim
                    && kind_reg == KIND_ALLOC)
                begin
                    we    = 1'b1;
                    waddr = scan_reg;
                end
                else if (free_reg[scan_reg] && {1'b0, scan_reg} < lim)
                begin
                    we    = 1'b1;
                    waddr = cur_reg;
                    wdata = {1'b0, scan_reg};
                end
            end
            S_LINK2:
            begin
                we    = 1'b1;
                waddr = found_reg;
            end
            S_WALK:
            begin
                raddr = nxt_blk;
                if (rdata[BLK_W] || steps_reg == (BLK_W+1)'(BLOCK_COUNT))
                begin
                    we    = 1'b1;
                    waddr = idx_reg;
                end
            end
            S_WAIT:   raddr = found_reg;
            S_IDLE:
            begin
                if (in_acc && kind == KIND_CLOSE && open_reg)
                begin
                    we    = 1'b1;
                    waddr = cur_reg;
                end
                raddr = block_index[BLK_W-1:0];
            end
            default:  ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (kind == KIND_ALLOC)
                        state_next = S_SRCH;
                    else if (kind == KIND_OPEN)
                        state_next = S_OPNRD;
                    else if (kind == KIND_APPND && open_reg
                             && {1'b0, fill_reg} >= cap_eff)
                        state_next = S_SRCH;
                    else if (kind == KIND_READ)
                        state_next = S_RDLNK;
                    else
                        state_next = S_DONE;
                end
            end
            S_SRCH:
            begin
                if (free_reg[scan_reg] && {1'b0, scan_reg} < lim)
                    state_next = (kind_reg == KIND_ALLOC) ? S_DONE : S_LINK2;
                else if (scan_end || {1'b0, scan_reg} >= lim)
                    state_next = S_DONE;
            end
            S_LINK2:  state_next = S_DONE;
            S_OPNRD:  state_next = S_WALK;
            S_WALK:
            begin
                if (rdata[BLK_W] || steps_reg == (BLK_W+1)'(BLOCK_COUNT))
                    state_next = S_DONE;
                else
                    state_next = S_WAIT;
            end
            S_WAIT:   state_next = S_WALK;
            S_RDLNK:  state_next = S_DONE;
            S_DONE:   if (res_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            free_reg     <= '1;
            cur_reg      <= '0;
            fill_reg     <= '0;
            open_reg     <= 1'b0;
            cap_reg      <= 12'd4092;
            use_reg      <= 9'd256;
            out_valid_reg <= 1'b0;
            r_status_reg <= ST_OK;
            r_end_reg    <= 1'b0;
            r_blk_reg    <= '0;
            r_off_reg    <= '0;
            r_byte_reg   <= '0;
            scan_reg     <= '0;
            found_reg    <= '0;
            steps_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == REG_CAP)
                    cap_reg <= pwdata[11:0];
                else
                    use_reg <= pwdata[8:0];
            end
            if (out_acc)
                out_valid_reg <= 1'b0;
            if (res_load)
                out_valid_reg <= 1'b1;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        r_status_reg <= ST_OK;
                        r_end_reg    <= 1'b0;
                        r_off_reg    <= '0;
                        r_byte_reg   <= '0;
                        r_blk_reg    <= '0;
                        scan_reg     <= '0;
                        steps_reg    <= '0;
                        if (kind == KIND_APPND || kind == KIND_CLOSE)
                        begin
                            if (!open_reg)
                                r_status_reg <= ST_NOWRITE;
                        end
                        if (kind == KIND_CLOSE && open_reg)
                            open_reg <= 1'b0;
                        if (kind == KIND_OPEN)
                            free_reg[block_index[BLK_W-1:0]] <= 1'b0;
                    end
                end
                S_SRCH:
                begin
                    if (free_reg[scan_reg] && {1'b0, scan_reg} < lim)
                    begin
                        free_reg[scan_reg] <= 1'b0;
                        found_reg          <= scan_reg;
                        if (kind_reg == KIND_ALLOC)
                            r_blk_reg <= scan_reg;
                        else
                        begin
                            cur_reg  <= scan_reg;
                            fill_reg <= '0;
                        end
                    end
                    else if (scan_end || {1'b0, scan_reg} >= lim)
                        r_status_reg <= ST_NOSPACE;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_WALK:
                begin
                    steps_reg <= steps_reg + 1'b1;
                    found_reg <= nxt_blk;
                    if (!rdata[BLK_W] && steps_reg != (BLK_W+1)'(BLOCK_COUNT)
                        && nxt_blk != idx_reg)
                        free_reg[nxt_blk] <= 1'b1;
                    if (rdata[BLK_W] || steps_reg == (BLK_W+1)'(BLOCK_COUNT))
                    begin
                        cur_reg  <= idx_reg;
                        fill_reg <= '0;
                        open_reg <= 1'b1;
                    end
                end
                S_RDLNK:
                begin
                    r_end_reg <= rdata[BLK_W];
                    r_blk_reg <= rdata[BLK_W] ? '0 : nxt_blk;
                end
                S_DONE:
                begin
                    if (res_load && kind_reg == KIND_APPND && open_reg
                        && r_status_reg == ST_OK)
                    begin
                        r_blk_reg  <= cur_reg;
                        r_off_reg  <= fill_reg;
                        r_byte_reg <= byte_reg;
                        fill_reg   <= fill_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Item payload capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg <= kind;
            idx_reg  <= block_index[BLK_W-1:0];
            byte_reg <= data_byte;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = r_status_reg;
    assign block_number = 8'(r_blk_reg);
    assign chain_end    = r_end_reg;
    assign byte_offset  = r_off_reg;
    assign byte_out     = r_byte_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_CAP) ? {20'd0, cap_reg} : {23'd0, use_reg};
endmodule

// File: rtl/core/fcba_checker.sv
// ---------------------------------------------------------------------------
// fcba_checker
// Port-level assertions for the chained block allocator.
// ---------------------------------------------------------------------------
`include "fat_chain_block_allocator_defines.svh"

module fcba_checker
    import fcba_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [7:0]  block_number,
    input logic        chain_end,
    input logic [11:0] byte_offset,
    input logic        pready
);
    `FCBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(block_number), "stalled result changed")
    `FCBA_ASSERT_IMPL(a_end_blk, clk, rst_n, out_valid && chain_end, block_number == 8'd0 && status == ST_OK, "chain end with block")
    `FCBA_ASSERT_IMPL(a_err_off, clk, rst_n, out_valid && status != ST_OK, byte_offset == 12'd0 && !chain_end, "error result has payload")
    `FCBA_ASSERT_IMPL(a_stall_busy, clk, rst_n, out_valid && out_stall, in_stall, "input taken while result blocked")
    `FCBA_ASSERT_IMPL(a_ready, clk, rst_n, 1'b1, pready, "pready low")
endmodule

bind fat_chain_block_allocator fcba_checker u_fcba_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .block_number(block_number), .chain_end(chain_end),
    .byte_offset(byte_offset), .pready(pready)
);

// File: bench/tb_fat_chain_block_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fat_chain_block_allocator
// Drives alloc, open, append, close, read-link and unused-kind transactions into the
// chained block allocator and checks every result against a predictor of the free
// map, the link table and the write cursor.
// ----------------------------------------------------------------------------
module tb_fat_chain_block_allocator
    import fcba_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [7:0]  block_index;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  block_number;
    logic        chain_end;
    logic [11:0] byte_offset;
    logic [7:0]  byte_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  block_number;
        logic        chain_end;
        logic [11:0] byte_offset;
        logic [7:0]  byte_out;
    } alloc_result_t;

    localparam logic [2:0] KIND_UNUSED = 3'd5;
    localparam logic [2:0] KIND_LAST   = 3'd7;

    // predictor state
    logic       blk_free [BLOCK_COUNT];
    logic       link_end [BLOCK_COUNT];
    blk_t       link_next [BLOCK_COUNT];
    logic       link_valid [BLOCK_COUNT];
    blk_t       cur_blk;
    int         fill_cnt;
    logic       wr_open;
    int         capacity;
    int         search_limit;

    alloc_result_t result_queue[$];
    int            error_count;
    logic          hold_off;

    fat_chain_block_allocator i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("fat_chain_block_allocator verification failed");
        $finish;
    end

    function automatic int find_free();
        int lim;
        lim = (search_limit > BLOCK_COUNT) ? BLOCK_COUNT : search_limit;
        for (int i = 0; i < lim; i++)
            if (blk_free[i])
                return i;
        return -1;
    endfunction

    function automatic alloc_result_t predict_alloc(logic [2:0] k, logic [7:0] idx,
                                                    logic [7:0] b);
        alloc_result_t r;
        int f;
        int cap;
        blk_t walk;
        logic done;
        r = '0;
        case (k)
            KIND_ALLOC:
            begin
                f = find_free();
                if (f < 0)
                    r.status = ST_NOSPACE;
                else
                begin
                    blk_free[f] = 1'b0;
                    link_end[f] = 1'b1;
                    link_valid[f] = 1'b1;
                    r.block_number = 8'(f);
                end
            end
            KIND_OPEN:
            begin
                blk_free[idx] = 1'b0;
                done = link_end[idx];
                walk = link_next[idx];
                for (int s = 0; s < BLOCK_COUNT && !done; s++)
                begin
                    if (walk != idx)
                        blk_free[walk] = 1'b1;
                    done = link_end[walk];
                    walk = link_next[walk];
                end
                link_end[idx] = 1'b1;
                link_valid[idx] = 1'b1;
                cur_blk = idx;
                fill_cnt = 0;
                wr_open = 1'b1;
            end
            KIND_APPND:
            begin
                cap = (capacity > BLOCK_BYTES) ? BLOCK_BYTES : capacity;
                if (!wr_open)
                    r.status = ST_NOWRITE;
                else
                begin
                    f = 0;
                    if (fill_cnt >= cap)
                    begin
                        f = find_free();
                        if (f >= 0)
                        begin
                            blk_free[f] = 1'b0;
                            link_end[cur_blk] = 1'b0;
                            link_next[cur_blk] = blk_t'(f);
                            link_end[f] = 1'b1;
                            link_valid[f] = 1'b1;
                            cur_blk = blk_t'(f);
                            fill_cnt = 0;
                        end
                    end
                    if (f < 0)
                        r.status = ST_NOSPACE;
                    else
                    begin
                        r.block_number = cur_blk;
                        r.byte_offset = 12'(fill_cnt);
                        r.byte_out = b;
                        fill_cnt++;
                    end
                end
            end
            KIND_CLOSE:
            begin
                if (!wr_open)
                    r.status = ST_NOWRITE;
                else
                begin
                    link_end[cur_blk] = 1'b1;
                    link_valid[cur_blk] = 1'b1;
                    wr_open = 1'b0;
                end
            end
            KIND_READ:
            begin
                if (link_end[idx])
                    r.chain_end = 1'b1;
                else
                    r.block_number = link_next[idx];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Every link reached from a written entry is written, so a written head is safe.
    function automatic logic [7:0] pick_written();
        int tries;
        logic [7:0] c;
        for (tries = 0; tries < 64; tries++)
        begin
            c = 8'($urandom_range(0, BLOCK_COUNT - 1));
            if (link_valid[c])
                return c;
        end
        for (int i = 0; i < BLOCK_COUNT; i++)
            if (link_valid[i])
                return 8'(i);
        return 8'd0;
    endfunction

    // Returns at the accepting edge; valid stays up when the next item follows
    task automatic send_item(logic [2:0] k, logic [7:0] idx, logic [7:0] b, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 5) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // an open or read of an unwritten entry is never issued
        if ((k == KIND_OPEN || k == KIND_READ) && !link_valid[idx])
            idx = pick_written();
        kind <= k;
        block_index <= idx;
        data_byte <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        result_queue.push_back(predict_alloc(k, idx, b));
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == {REG_CAP, 2'b00})
            capacity = int'(data[11:0]);
        else
            search_limit = int'(data[8:0]);
    endtask

    task automatic drain_and_config(int cap, int lim);
        in_valid <= 1'b0;
        while (result_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        apb_write({REG_CAP, 2'b00}, cap);
        @(posedge clk);
        apb_write({REG_USE, 2'b00}, lim);
    endtask

    // result checker
    always @(posedge clk)
    begin
        alloc_result_t got;
        alloc_result_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, block_number, chain_end, byte_offset, byte_out};
            if (result_queue.size() == 0)
            begin
                $display("%0t: unexpected result, actual %p", $time, got);
                error_count++;
            end
            else
            begin
                exp = result_queue.pop_front();
                if (got.status != exp.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp.status,
                             got.status);
                    error_count++;
                end
                if (got.block_number != exp.block_number)
                begin
                    $display("%0t: block_number expected %0d actual %0d", $time,
                             exp.block_number, got.block_number);
                    error_count++;
                end
                if (got.chain_end != exp.chain_end)
                begin
                    $display("%0t: chain_end expected %0d actual %0d", $time,
                             exp.chain_end, got.chain_end);
                    error_count++;
                end
                if (got.byte_offset != exp.byte_offset)
                begin
                    $display("%0t: byte_offset expected %0d actual %0d", $time,
                             exp.byte_offset, got.byte_offset);
                    error_count++;
                end
                if (got.byte_out != exp.byte_out)
                begin
                    $display("%0t: byte_out expected %0d actual %0d", $time,
                             exp.byte_out, got.byte_out);
                    error_count++;
                end
            end
        end
    end

    // receiver stall: random per transaction, long stretch on request
    initial
    begin
        int wait_cycles;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (60) @(posedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                if (wait_cycles != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic test_directed();
        send_item(KIND_APPND, 8'd0, 8'hFF, 1'b0);
        send_item(KIND_CLOSE, 8'd0, 8'd0, 1'b0);
        send_item(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
        send_item(KIND_READ, 8'd0, 8'd0, 1'b0);
        send_item(KIND_OPEN, 8'd0, 8'd0, 1'b0);
        for (int i = 0; i < 6; i++)
            send_item(KIND_APPND, 8'd0, i[0] ? 8'hFF : 8'h00, 1'b0);
        send_item(KIND_CLOSE, 8'd0, 8'd0, 1'b0);
        send_item(KIND_READ, 8'd0, 8'd0, 1'b0);
        send_item(KIND_OPEN, 8'd0, 8'd0, 1'b0);
        send_item(KIND_CLOSE, 8'd0, 8'd0, 1'b0);
        send_item(KIND_UNUSED, 8'hFF, 8'hFF, 1'b0);
        send_item(KIND_LAST, 8'hAA, 8'h55, 1'b0);
        send_item(KIND_READ, 8'hFF, 8'd0, 1'b0);
    endtask

    task automatic test_capacity_zero();
        drain_and_config(0, 256);
        send_item(KIND_OPEN, 8'd0, 8'd0, 1'b0);
        for (int i = 0; i < 5; i++)
            send_item(KIND_APPND, 8'd0, 8'($urandom), 1'b0);
        send_item(KIND_CLOSE, 8'd0, 8'd0, 1'b0);
        send_item(KIND_OPEN, 8'd0, 8'd0, 1'b0);
    endtask

    task automatic test_out_of_space();
        drain_and_config(1, 1);
        send_item(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
        send_item(KIND_OPEN, 8'd255, 8'd0, 1'b0);
        send_item(KIND_APPND, 8'd0, 8'h11, 1'b0);
        send_item(KIND_APPND, 8'd0, 8'h22, 1'b0);
        send_item(KIND_CLOSE, 8'd0, 8'd0, 1'b0);
        send_item(KIND_OPEN, 8'd255, 8'd0, 1'b0);
        send_item(KIND_CLOSE, 8'd0, 8'd0, 1'b0);
    endtask

    task automatic test_backpressure();
        drain_and_config(4092, 256);
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(i[0] ? KIND_READ : KIND_ALLOC, 8'd0, 8'd0, 1'b0);
    endtask

    task automatic random_phase(int n, int cap, int lim);
        int sel;
        drain_and_config(cap, lim);
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
                send_item(KIND_APPND, 8'd0, 8'($urandom), 1'b1);
            else if (sel < 62)
                send_item(KIND_ALLOC, 8'd0, 8'd0, 1'b1);
            else if (sel < 72)
                send_item(KIND_OPEN, 8'($urandom), 8'd0, 1'b1);
            else if (sel < 80)
                send_item(KIND_CLOSE, 8'($urandom), 8'($urandom), 1'b1);
            else if (sel < 97)
                send_item(KIND_READ, 8'($urandom), 8'd0, 1'b1);
            else
                send_item(3'($urandom_range(KIND_UNUSED, KIND_LAST)), 8'($urandom),
                          8'($urandom), 1'b1);
        end
    endtask

    initial
    begin
        error_count = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        block_index = '0;
        data_byte = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < BLOCK_COUNT; i++)
        begin
            blk_free[i] = 1'b1;
            link_end[i] = 1'b0;
            link_next[i] = '0;
            link_valid[i] = 1'b0;
        end
        cur_blk = '0;
        fill_cnt = 0;
        wr_open = 1'b0;
        capacity = 4092;
        search_limit = 256;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity_zero();
        test_out_of_space();
        test_backpressure();
        random_phase(400, 3, 256);
        random_phase(300, 1, 40);
        random_phase(300, 4095, 256);
        random_phase(300, 2, 511);
        random_phase(300, 7, 16);
        random_phase(300, 0, 200);

        in_valid <= 1'b0;
        while (result_queue.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (error_count == 0 && result_queue.size() == 0)
            $display("fat_chain_block_allocator verification clean");
        else
            $display("fat_chain_block_allocator verification failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/fcba_pkg.sv
rtl/core/fcba_ram.sv
rtl/core/fat_chain_block_allocator.sv
rtl/core/fcba_checker.sv
bench/tb_fat_chain_block_allocator.sv
